/* hw/rtl/dnts_pkg.sv */
// Shared types, character codes and saturation limits for the number token scanner.
package dnts_pkg;

  // Digit limits of the accumulators
  localparam int MAX_DIGITS     = 18;
  localparam int MAX_EXP_DIGITS = 4;

  localparam logic [63:0] CAP60 = 64'h0FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CAP14 = 64'h0000_0000_0000_3FFF;

  // Largest value of ndig decimal digits, clipped to cap (elaboration only)
  function automatic logic [63:0] sat_limit(int ndig, logic [63:0] cap);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < ndig; i++) begin
      if (p <= cap) begin
        p = p * 64'd10;
      end
    end
    p = p - 64'd1;
    return (p > cap) ? cap : p;
  endfunction

  localparam logic [63:0] LIM_MANT = sat_limit(MAX_DIGITS, CAP60);
  localparam logic [63:0] LIM_EXP  = sat_limit(MAX_EXP_DIGITS, CAP14);

  // Character codes
  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  // Field widths and result beat layout
  localparam int ACC_W     = 60;
  localparam int CNT_W     = 5;
  localparam int EXP_W     = 14;
  localparam int TDATA_W   = 144;
  localparam int OFS_NEG   = 0;
  localparam int OFS_INT   = 1;
  localparam int OFS_FRAC  = 61;
  localparam int OFS_FCNT  = 121;
  localparam int OFS_ENEG  = 126;
  localparam int OFS_EXP   = 127;

  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_SIGN       = 4'd1,
    PH_INT        = 4'd2,
    PH_INT_POINT  = 4'd3,
    PH_LEAD_POINT = 4'd4,
    PH_FRAC       = 4'd5,
    PH_EXP_MARK   = 4'd6,
    PH_EXP_SIGN   = 4'd7,
    PH_EXP_DIG    = 4'd8,
    PH_BAD        = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_INT    = 2'd0,
    KIND_FLOAT  = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_OVF    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              negative;
    logic [ACC_W-1:0]  int_part;
    logic [ACC_W-1:0]  frac_value;
    logic [CNT_W-1:0]  frac_count;
    logic              exp_negative;
    logic [EXP_W-1:0]  exp_value;
  } result_t;

  // Held byte handed from the input register to the scanner core
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } item_t;

  // Exponent marker letters: e s f d l in either case
  function automatic logic is_marker(logic [7:0] c);
    logic m;
    unique case (c)
      8'h65, 8'h73, 8'h66, 8'h64, 8'h6C,
      8'h45, 8'h53, 8'h46, 8'h44, 8'h4C: m = 1'b1;
      default:                           m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

/* hw/rtl/dnts_in_reg.sv */
// Input register: holds one character beat until the scanner core takes it.
module dnts_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // [7:0] ch
  input  logic            advance,
  output dnts_pkg::item_t item
);

  logic       valid_r, valid_nxt;
  logic [7:0] ch_r;

  // Take a beat when empty or when the held one moves on this cycle
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the character
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r <= in_tdata;
    end
  end

  assign item.valid = valid_r;
  assign item.ch    = ch_r;

endmodule

/* hw/rtl/dnts_core.sv */
// Scanner core: grammar state machine, multiply-by-ten accumulators and result build.
module dnts_core (
  input  logic              clk,
  input  logic              rst_n,
  input  dnts_pkg::item_t   item,
  input  logic              out_free,
  output logic              advance,
  output logic              emit,
  output dnts_pkg::result_t res
);

  dnts_pkg::phase_t phase_r, phase_nxt;
  logic                         neg_r, neg_nxt;
  logic [dnts_pkg::ACC_W-1:0]   int_acc_r, int_acc_nxt;
  logic [dnts_pkg::ACC_W-1:0]   frac_acc_r, frac_acc_nxt;
  logic [dnts_pkg::CNT_W-1:0]   frac_cnt_r, frac_cnt_nxt;
  logic                         exp_neg_r, exp_neg_nxt;
  logic [dnts_pkg::EXP_W-1:0]   exp_acc_r, exp_acc_nxt;
  logic                         ovf_r, ovf_nxt;

  logic       is_end, is_dig, is_pt, is_minus, is_plus, is_mark;
  logic [3:0] dig;
  logic       int_dig, frac_dig, exp_dig, set_neg, set_exp_neg;
  logic [63:0] int_cand, frac_cand;
  logic [17:0] exp_cand;
  logic       int_sat, frac_sat, exp_sat, frac_full;
  dnts_pkg::kind_t kind;

  // Classify the held character
  always_comb begin
    is_end   = (item.ch == dnts_pkg::CH_END);
    is_dig   = (item.ch >= dnts_pkg::CH_ZERO) && (item.ch <= dnts_pkg::CH_NINE);
    is_pt    = (item.ch == dnts_pkg::CH_POINT);
    is_minus = (item.ch == dnts_pkg::CH_MINUS);
    is_plus  = (item.ch == dnts_pkg::CH_PLUS);
    is_mark  = dnts_pkg::is_marker(item.ch);
    dig      = 4'(item.ch - dnts_pkg::CH_ZERO);
  end

  // An end beat needs a free result slot; other beats always move on
  assign advance = item.valid && (!is_end || out_free);
  assign emit    = advance && is_end;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      dnts_pkg::PH_START: begin
        if (is_minus || is_plus)  phase_nxt = dnts_pkg::PH_SIGN;
        else if (is_dig)          phase_nxt = dnts_pkg::PH_INT;
        else if (is_pt)           phase_nxt = dnts_pkg::PH_LEAD_POINT;
        else                      phase_nxt = dnts_pkg::PH_BAD;
      end
      dnts_pkg::PH_SIGN: begin
        if (is_dig)               phase_nxt = dnts_pkg::PH_INT;
        else if (is_pt)           phase_nxt = dnts_pkg::PH_LEAD_POINT;
        else                      phase_nxt = dnts_pkg::PH_BAD;
      end
      dnts_pkg::PH_INT: begin
        if (is_dig)               phase_nxt = dnts_pkg::PH_INT;
        else if (is_pt)           phase_nxt = dnts_pkg::PH_INT_POINT;
        else if (is_mark)         phase_nxt = dnts_pkg::PH_EXP_MARK;
        else                      phase_nxt = dnts_pkg::PH_BAD;
      end
      dnts_pkg::PH_INT_POINT, dnts_pkg::PH_LEAD_POINT: begin
        if (is_dig)               phase_nxt = dnts_pkg::PH_FRAC;
        else                      phase_nxt = dnts_pkg::PH_BAD;
      end
      dnts_pkg::PH_FRAC: begin
        if (is_dig)               phase_nxt = dnts_pkg::PH_FRAC;
        else if (is_mark)         phase_nxt = dnts_pkg::PH_EXP_MARK;
        else                      phase_nxt = dnts_pkg::PH_BAD;
      end
      dnts_pkg::PH_EXP_MARK: begin
        if (is_minus || is_plus)  phase_nxt = dnts_pkg::PH_EXP_SIGN;
        else if (is_dig)          phase_nxt = dnts_pkg::PH_EXP_DIG;
        else                      phase_nxt = dnts_pkg::PH_BAD;
      end
      dnts_pkg::PH_EXP_SIGN, dnts_pkg::PH_EXP_DIG: begin
        if (is_dig)               phase_nxt = dnts_pkg::PH_EXP_DIG;
        else                      phase_nxt = dnts_pkg::PH_BAD;
      end
      default:                    phase_nxt = dnts_pkg::PH_BAD;
    endcase
    if (is_end) phase_nxt = dnts_pkg::PH_START;
  end

  // Actions per phase
  always_comb begin
    int_dig     = 1'b0;
    frac_dig    = 1'b0;
    exp_dig     = 1'b0;
    set_neg     = 1'b0;
    set_exp_neg = 1'b0;
    unique case (phase_r)
      dnts_pkg::PH_START: begin
        int_dig = is_dig;
        set_neg = is_minus;
      end
      dnts_pkg::PH_SIGN, dnts_pkg::PH_INT:                 int_dig  = is_dig;
      dnts_pkg::PH_INT_POINT, dnts_pkg::PH_LEAD_POINT,
      dnts_pkg::PH_FRAC:                                   frac_dig = is_dig;
      dnts_pkg::PH_EXP_MARK: begin
        exp_dig     = is_dig;
        set_exp_neg = is_minus;
      end
      dnts_pkg::PH_EXP_SIGN, dnts_pkg::PH_EXP_DIG:         exp_dig  = is_dig;
      default: ;
    endcase
  end

  // Multiply by ten as shift-add, then compare against the limit
  always_comb begin
    int_cand  = ({4'b0, int_acc_r} << 3) + ({4'b0, int_acc_r} << 1) + 64'(dig);
    frac_cand = ({4'b0, frac_acc_r} << 3) + ({4'b0, frac_acc_r} << 1) + 64'(dig);
    exp_cand  = ({4'b0, exp_acc_r} << 3) + ({4'b0, exp_acc_r} << 1) + 18'(dig);
    int_sat   = (int_cand > dnts_pkg::LIM_MANT);
    frac_sat  = (frac_cand > dnts_pkg::LIM_MANT);
    exp_sat   = (exp_cand > dnts_pkg::LIM_EXP[17:0]);
    frac_full = (frac_cnt_r >= dnts_pkg::CNT_W'(dnts_pkg::MAX_DIGITS));
  end

  // Accumulator updates
  always_comb begin
    neg_nxt      = neg_r;
    int_acc_nxt  = int_acc_r;
    frac_acc_nxt = frac_acc_r;
    frac_cnt_nxt = frac_cnt_r;
    exp_neg_nxt  = exp_neg_r;
    exp_acc_nxt  = exp_acc_r;
    ovf_nxt      = ovf_r;
    if (is_end) begin
      neg_nxt      = 1'b0;
      int_acc_nxt  = '0;
      frac_acc_nxt = '0;
      frac_cnt_nxt = '0;
      exp_neg_nxt  = 1'b0;
      exp_acc_nxt  = '0;
      ovf_nxt      = 1'b0;
    end else begin
      if (set_neg)     neg_nxt     = 1'b1;
      if (set_exp_neg) exp_neg_nxt = 1'b1;
      if (int_dig) begin
        if (int_sat) begin
          int_acc_nxt = dnts_pkg::LIM_MANT[dnts_pkg::ACC_W-1:0];
          ovf_nxt     = 1'b1;
        end else begin
          int_acc_nxt = int_cand[dnts_pkg::ACC_W-1:0];
        end
      end
      if (frac_dig) begin
        if (frac_full) begin
          ovf_nxt = 1'b1;
        end else begin
          frac_cnt_nxt = frac_cnt_r + 1'b1;
          if (frac_sat) begin
            frac_acc_nxt = dnts_pkg::LIM_MANT[dnts_pkg::ACC_W-1:0];
            ovf_nxt      = 1'b1;
          end else begin
            frac_acc_nxt = frac_cand[dnts_pkg::ACC_W-1:0];
          end
        end
      end
      if (exp_dig) begin
        if (exp_sat) begin
          exp_acc_nxt = dnts_pkg::LIM_EXP[dnts_pkg::EXP_W-1:0];
          ovf_nxt     = 1'b1;
        end else begin
          exp_acc_nxt = exp_cand[dnts_pkg::EXP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= dnts_pkg::PH_START;
      neg_r      <= 1'b0;
      int_acc_r  <= '0;
      frac_acc_r <= '0;
      frac_cnt_r <= '0;
      exp_neg_r  <= 1'b0;
      exp_acc_r  <= '0;
      ovf_r      <= 1'b0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      int_acc_r  <= int_acc_nxt;
      frac_acc_r <= frac_acc_nxt;
      frac_cnt_r <= frac_cnt_nxt;
      exp_neg_r  <= exp_neg_nxt;
      exp_acc_r  <= exp_acc_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // Classify the finished token
  always_comb begin
    unique case (phase_r)
      dnts_pkg::PH_INT, dnts_pkg::PH_INT_POINT: kind = dnts_pkg::KIND_INT;
      dnts_pkg::PH_FRAC, dnts_pkg::PH_EXP_DIG:  kind = dnts_pkg::KIND_FLOAT;
      default:                                  kind = dnts_pkg::KIND_REJECT;
    endcase
    if (kind != dnts_pkg::KIND_REJECT && ovf_r) kind = dnts_pkg::KIND_OVF;
  end

  // Build the result; a rejected token carries zero fields
  always_comb begin
    res      = '0;
    res.kind = kind;
    if (kind != dnts_pkg::KIND_REJECT) begin
      res.negative     = neg_r;
      res.int_part     = int_acc_r;
      res.frac_value   = frac_acc_r;
      res.frac_count   = frac_cnt_r;
      res.exp_negative = exp_neg_r;
      res.exp_value    = exp_acc_r;
    end
  end

endmodule

/* hw/rtl/dnts_out_reg.sv */
// Output register: holds one result beat until the downstream side takes it.
module dnts_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  dnts_pkg::result_t             res,
  output logic                          out_free,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dnts_pkg::TDATA_W-1:0]  out_tdata,
  output logic [1:0]                    out_tuser
);

  logic              valid_r, valid_nxt;
  dnts_pkg::result_t res_r;

  // Slot is free when empty or being drained this cycle
  assign out_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  // Pack the beat, first field lowest
  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {3'b000, res_r.exp_value, res_r.exp_negative, res_r.frac_count,
                       res_r.frac_value, res_r.int_part, res_r.negative};

endmodule

/* hw/rtl/decimal_number_token_scanner.sv */
// Top level of the decimal number token scanner.
// A result beat is loaded into the output register when its end byte leaves the input register
// with the result slot free; a stalled result holds the end byte in the input register.
// Throughput: one character byte per cycle while no end byte waits on a full result slot;
// set by the state and multiply-by-ten update that the scanner core makes for each byte.
// Reset: synchronous, active low; clears both registers' valid bits and returns the
// scanner to the start of a token with all accumulators at zero.
module decimal_number_token_scanner (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] ch
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] negative, [60:1] int_part, [120:61] frac_value, [125:121] frac_count,
  // [126] exp_negative, [140:127] exp_value, [143:141] zero
  output logic [dnts_pkg::TDATA_W-1:0]  out_tdata,
  output logic [1:0]                    out_tuser   // [1:0] kind
);

  dnts_pkg::item_t   item;
  dnts_pkg::result_t res;
  logic              advance, emit, out_free;

  dnts_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .item      (item)
  );

  dnts_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (item),
    .out_free (out_free),
    .advance  (advance),
    .emit     (emit),
    .res      (res)
  );

  dnts_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* hw/rtl/dnts_checker.sv */
// Port-level checks for the number token scanner, bound to the top level.
module dnts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [dnts_pkg::TDATA_W-1:0]  out_tdata,
  input logic [1:0]                    out_tuser
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Drop all fields of a rejected token
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == dnts_pkg::KIND_REJECT |-> out_tdata == '0)
    else $error("rejected token carries non-zero fields");

  // Integer results carry no fraction or exponent
  a_int_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == dnts_pkg::KIND_INT
    |-> out_tdata[dnts_pkg::TDATA_W-1:dnts_pkg::OFS_FRAC] == '0)
    else $error("integer result with fraction or exponent");

  // Fraction count never passes the digit limit
  a_frac_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[dnts_pkg::OFS_ENEG-1:dnts_pkg::OFS_FCNT]
                   <= dnts_pkg::CNT_W'(dnts_pkg::MAX_DIGITS))
    else $error("fraction digit count above limit");

  // No result beat straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind decimal_number_token_scanner dnts_checker u_dnts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* test/testbench.sv */
// Self-checking testbench for the decimal number token scanner: predicts each token result.
module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 8;
  localparam int SIDE_IN        = 0;
  localparam int SIDE_OUT       = 1;
  localparam logic [63:0] MANT_LIM = 64'd999_999_999_999_999_999;
  localparam logic [63:0] EXP_LIM  = 64'd9999;
  localparam string MARKERS = "esfdlESFDL";
  localparam string GRAMMAR = "0123456789+-.eE";

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [7:0]                     in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [dnts_pkg::TDATA_W-1:0]   out_tdata;
  logic [1:0]                     out_tuser;

  // Scanner state as predicted
  dnts_pkg::phase_t scan_phase;
  logic        scan_neg;
  logic [63:0] scan_int;
  logic [63:0] scan_frac;
  logic [4:0]  scan_fcount;
  logic        scan_eneg;
  logic [63:0] scan_exp;
  logic        scan_ovf;

  dnts_pkg::result_t expected_tokens[$];
  logic [7:0]  token_buf[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          stretch_left[2] = '{0, 0};
  bit          stretch_calm[2] = '{1'b0, 1'b0};
  bit          in_no_idle;
  bit          hold_request;

  decimal_number_token_scanner u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit is_dec(logic [7:0] c);
    return c >= dnts_pkg::CH_ZERO && c <= dnts_pkg::CH_NINE;
  endfunction

  function automatic bit exp_letter(logic [7:0] c);
    for (int i = 0; i < 10; i++) begin
      if (c == MARKERS[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Shift in one decimal digit; pin at the limit and flag overflow
  function automatic logic [63:0] ten_add(logic [63:0] acc, logic [63:0] d, logic [63:0] lim);
    if (acc > (lim - d) / 64'd10) begin
      scan_ovf = 1'b1;
      return lim;
    end
    return acc * 64'd10 + d;
  endfunction

  function automatic void clear_scan();
    scan_phase  = dnts_pkg::PH_START;
    scan_neg    = 1'b0;
    scan_int    = '0;
    scan_frac   = '0;
    scan_fcount = '0;
    scan_eneg   = 1'b0;
    scan_exp    = '0;
    scan_ovf    = 1'b0;
  endfunction

  function automatic void frac_push(logic [63:0] d);
    if (scan_fcount >= dnts_pkg::MAX_DIGITS) begin
      scan_ovf = 1'b1;
    end else begin
      scan_fcount = scan_fcount + 5'd1;
      scan_frac   = ten_add(scan_frac, d, MANT_LIM);
    end
  endfunction

  // Advance the predicted scanner by one accepted byte
  function automatic void scan_char(logic [7:0] c);
    logic [63:0]       d;
    dnts_pkg::kind_t   k;
    dnts_pkg::result_t r;
    d = 64'(c) - 64'(dnts_pkg::CH_ZERO);
    if (c == dnts_pkg::CH_END) begin
      case (scan_phase)
        dnts_pkg::PH_INT, dnts_pkg::PH_INT_POINT: k = dnts_pkg::KIND_INT;
        dnts_pkg::PH_FRAC, dnts_pkg::PH_EXP_DIG:  k = dnts_pkg::KIND_FLOAT;
        default:                                  k = dnts_pkg::KIND_REJECT;
      endcase
      if (k != dnts_pkg::KIND_REJECT && scan_ovf) k = dnts_pkg::KIND_OVF;
      r = '0;
      r.kind = k;
      if (k != dnts_pkg::KIND_REJECT) begin
        r.negative     = scan_neg;
        r.int_part     = scan_int[dnts_pkg::ACC_W-1:0];
        r.frac_value   = scan_frac[dnts_pkg::ACC_W-1:0];
        r.frac_count   = scan_fcount;
        r.exp_negative = scan_eneg;
        r.exp_value    = scan_exp[dnts_pkg::EXP_W-1:0];
      end
      expected_tokens.push_back(r);
      clear_scan();
      return;
    end
    case (scan_phase)
      dnts_pkg::PH_START, dnts_pkg::PH_SIGN: begin
        if (scan_phase == dnts_pkg::PH_START && c == dnts_pkg::CH_MINUS) begin
          scan_neg   = 1'b1;
          scan_phase = dnts_pkg::PH_SIGN;
        end else if (scan_phase == dnts_pkg::PH_START && c == dnts_pkg::CH_PLUS) begin
          scan_phase = dnts_pkg::PH_SIGN;
        end else if (is_dec(c)) begin
          scan_int   = ten_add(scan_int, d, MANT_LIM);
          scan_phase = dnts_pkg::PH_INT;
        end else if (c == dnts_pkg::CH_POINT) begin
          scan_phase = dnts_pkg::PH_LEAD_POINT;
        end else begin
          scan_phase = dnts_pkg::PH_BAD;
        end
      end
      dnts_pkg::PH_INT: begin
        if (is_dec(c))                    scan_int = ten_add(scan_int, d, MANT_LIM);
        else if (c == dnts_pkg::CH_POINT) scan_phase = dnts_pkg::PH_INT_POINT;
        else if (exp_letter(c))           scan_phase = dnts_pkg::PH_EXP_MARK;
        else                              scan_phase = dnts_pkg::PH_BAD;
      end
      dnts_pkg::PH_INT_POINT, dnts_pkg::PH_LEAD_POINT: begin
        if (is_dec(c)) begin
          frac_push(d);
          scan_phase = dnts_pkg::PH_FRAC;
        end else begin
          scan_phase = dnts_pkg::PH_BAD;
        end
      end
      dnts_pkg::PH_FRAC: begin
        if (is_dec(c))           frac_push(d);
        else if (exp_letter(c))  scan_phase = dnts_pkg::PH_EXP_MARK;
        else                     scan_phase = dnts_pkg::PH_BAD;
      end
      dnts_pkg::PH_EXP_MARK, dnts_pkg::PH_EXP_SIGN, dnts_pkg::PH_EXP_DIG: begin
        if (scan_phase == dnts_pkg::PH_EXP_MARK && c == dnts_pkg::CH_MINUS) begin
          scan_eneg  = 1'b1;
          scan_phase = dnts_pkg::PH_EXP_SIGN;
        end else if (scan_phase == dnts_pkg::PH_EXP_MARK && c == dnts_pkg::CH_PLUS) begin
          scan_phase = dnts_pkg::PH_EXP_SIGN;
        end else if (is_dec(c)) begin
          scan_exp   = ten_add(scan_exp, d, EXP_LIM);
          scan_phase = dnts_pkg::PH_EXP_DIG;
        end else begin
          scan_phase = dnts_pkg::PH_BAD;
        end
      end
      default: scan_phase = dnts_pkg::PH_BAD;
    endcase
  endfunction

  // ---------------------------------------------------------------- idling
  // Draw random stretches, either calm (no gaps) or busy (an idle gap drawn anew before each beat)
  function automatic int draw_wait(int side);
    if (side == SIDE_IN && in_no_idle) return 0;
    if (stretch_left[side] == 0) begin
      stretch_left[side] = $urandom_range(10, 50);
      stretch_calm[side] = ($urandom_range(0, 2) == 0);
    end
    stretch_left[side]--;
    return stretch_calm[side] ? 0 : $urandom_range(0, 18);
  endfunction

  // ---------------------------------------------------------------- sender
  // Offer one byte from a falling edge; return on the falling edge after acceptance
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = draw_wait(SIDE_IN);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (in_tready !== 1'b1);
    scan_char(c);
    @(negedge clk);
  endtask

  task automatic send_token();
    foreach (token_buf[i]) send_char(token_buf[i]);
    send_char(dnts_pkg::CH_END);
  endtask

  task automatic send_text(input string s);
    token_buf.delete();
    for (int i = 0; i < s.len(); i++) token_buf.push_back(s[i]);
    send_token();
  endtask

  // ---------------------------------------------------------------- token builders
  function automatic logic [7:0] rand_digit(bit long_run);
    if (long_run && $urandom_range(0, 1) == 1) return dnts_pkg::CH_NINE;
    return dnts_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic int part_len(bit long_run);
    if (long_run && $urandom_range(0, 1) == 1) return $urandom_range(14, 22);
    return $urandom_range(1, 4);
  endfunction

  // Build a well-formed number; long runs push the parts past their digit limits
  task automatic build_number(input bit long_run);
    int form;
    int n;
    token_buf.delete();
    case ($urandom_range(0, 3))
      0:       token_buf.push_back(dnts_pkg::CH_MINUS);
      1:       token_buf.push_back(dnts_pkg::CH_PLUS);
      default: ;
    endcase
    form = $urandom_range(0, 3);
    if (form != 0) begin
      n = part_len(long_run);
      repeat (n) token_buf.push_back(rand_digit(long_run));
    end
    if (form != 3) token_buf.push_back(dnts_pkg::CH_POINT);
    if (form == 0 || form == 2) begin
      n = part_len(long_run);
      repeat (n) token_buf.push_back(rand_digit(long_run));
    end
    // exponent, never straight after a bare trailing point
    if (form != 1 && $urandom_range(0, 1) == 1) begin
      token_buf.push_back(MARKERS[$urandom_range(0, 9)]);
      case ($urandom_range(0, 2))
        0:       token_buf.push_back(dnts_pkg::CH_MINUS);
        1:       token_buf.push_back(dnts_pkg::CH_PLUS);
        default: ;
      endcase
      n = (long_run && $urandom_range(0, 1) == 1) ? $urandom_range(3, 6) : $urandom_range(1, 3);
      repeat (n) token_buf.push_back(rand_digit(long_run));
    end
  endtask

  // Damage a token: stray byte, lost byte or a dangling exponent marker
  task automatic break_token();
    case ($urandom_range(0, 2))
      0: token_buf.insert($urandom_range(0, token_buf.size()), 8'($urandom_range(1, 255)));
      1: if (token_buf.size() > 0) token_buf.delete($urandom_range(0, token_buf.size() - 1));
      default: token_buf.push_back(MARKERS[$urandom_range(0, 9)]);
    endcase
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_text("0");
    send_text("-0");
    send_text("+7");
    send_text("12.");
    send_text("-12.5");
    send_text(".5");
    send_text("-.25e+3");
    send_text("1e5");
    send_text("7E-9");
    send_text("3s2");
    send_text("3f2");
    send_text("3d2");
    send_text("3l2");
    send_text("3S2");
    send_text("3F2");
    send_text("3D2");
    send_text("3L2");
    send_text("1e9999");
    // rejected shapes
    send_text("");
    send_text("-");
    send_text("+.");
    send_text("1e");
    send_text("1e-");
    send_text("1.e5");
    send_text("12a3");
    send_text("1e+x9");
    token_buf.delete();
    token_buf.push_back(8'hFF);
    send_token();
  endtask

  task automatic test_number_mix();
    repeat (65) begin
      build_number(1'b0);
      if ($urandom_range(0, 4) == 0) break_token();
      send_token();
    end
  endtask

  task automatic test_saturation();
    repeat (16) begin
      build_number(1'b1);
      // overflow followed by a bad byte must still reject
      if ($urandom_range(0, 5) == 0) break_token();
      send_token();
    end
  endtask

  task automatic test_noise();
    int n;
    repeat (40) begin
      token_buf.delete();
      n = $urandom_range(0, 8);
      repeat (n) begin
        if ($urandom_range(0, 1) == 1) token_buf.push_back(8'($urandom_range(1, 255)));
        else token_buf.push_back(GRAMMAR[$urandom_range(0, GRAMMAR.len() - 1)]);
      end
      send_token();
    end
  endtask

  // Hold the result side off for a long stretch while bytes keep coming
  task automatic test_backpressure();
    in_no_idle   = 1'b1;
    hold_request = 1'b1;
    repeat (20) begin
      build_number(1'b0);
      send_token();
    end
    in_no_idle   = 1'b0;
    hold_request = 1'b0;
  endtask

  // ---------------------------------------------------------------- result side
  initial begin : result_sink
    int pause;
    bit hold_done;
    out_tready = 1'b0;
    hold_done  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      pause = draw_wait(SIDE_OUT);
      if (hold_request && !hold_done) begin
        pause     = pause + LONG_HOLD;
        hold_done = 1'b1;
      end
      if (pause > 0) begin
        out_tready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    dnts_pkg::result_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (expected_tokens.size() == 0) begin
        $error("result beat with no token pending");
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("kind", 64'(want.kind), 64'(out_tuser));
        check_field("negative", 64'(want.negative),
                    64'(out_tdata[dnts_pkg::OFS_NEG]));
        check_field("int_part", 64'(want.int_part),
                    64'(out_tdata[dnts_pkg::OFS_INT +: dnts_pkg::ACC_W]));
        check_field("frac_value", 64'(want.frac_value),
                    64'(out_tdata[dnts_pkg::OFS_FRAC +: dnts_pkg::ACC_W]));
        check_field("frac_count", 64'(want.frac_count),
                    64'(out_tdata[dnts_pkg::OFS_FCNT +: dnts_pkg::CNT_W]));
        check_field("exp_negative", 64'(want.exp_negative),
                    64'(out_tdata[dnts_pkg::OFS_ENEG]));
        check_field("exp_value", 64'(want.exp_value),
                    64'(out_tdata[dnts_pkg::OFS_EXP +: dnts_pkg::EXP_W]));
        check_field("pad", 64'd0,
                    64'(out_tdata[dnts_pkg::TDATA_W-1:dnts_pkg::OFS_EXP+dnts_pkg::EXP_W]));
      end
    end
  end

  // Stop the run when neither side has moved a beat for too long
  always @(posedge clk) begin
    if ((in_tvalid === 1'b1 && in_tready === 1'b1) ||
        (out_tvalid === 1'b1 && out_tready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("decimal_number_token_scanner test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_no_idle   = 1'b0;
    hold_request = 1'b0;
    clear_scan();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_number_mix();
    test_saturation();
    test_noise();
    test_backpressure();
    test_number_mix();

    // drain: wait for every token result, then let the clock run on before the verdict
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("decimal_number_token_scanner test passed");
    end else begin
      $display("decimal_number_token_scanner test failed");
    end
    $finish;
  end

endmodule
